@@ src/assert_macros.svh @@
// Assertion macros for the file that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

@@ src/bsot_pkg.sv @@
// Types and constants shared by the box set overlap test block.
`default_nettype none

package bsot_pkg;

   localparam int FIELD_BITS  = 16;
   localparam int COORD_LIMIT = 32;
   localparam int OPCODE_BITS = 3;
   localparam int INDEX_BITS  = 4;
   localparam int USED_BITS   = 5;

   typedef enum logic [OPCODE_BITS-1:0] {
      OP_APPEND_OWN      = 3'd0,
      OP_APPEND_OTHER    = 3'd1,
      OP_OVERWRITE_OWN   = 3'd2,
      OP_OVERWRITE_OTHER = 3'd3,
      OP_CLEAR_OWN       = 3'd4,
      OP_CLEAR_OTHER     = 3'd5,
      OP_TEST            = 3'd6
   } opcode_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_RANGE = 2'd2
   } status_type;

   typedef struct packed {
      opcode_type                    opcode;
      logic [INDEX_BITS-1:0]         index;
      logic signed [FIELD_BITS-1:0]  box_left;
      logic signed [FIELD_BITS-1:0]  box_top;
      logic signed [FIELD_BITS-1:0]  box_right;
      logic signed [FIELD_BITS-1:0]  box_bottom;
      logic signed [FIELD_BITS-1:0]  own_x;
      logic signed [FIELD_BITS-1:0]  own_y;
      logic signed [FIELD_BITS-1:0]  other_x;
      logic signed [FIELD_BITS-1:0]  other_y;
   } req_word_type;

   typedef struct packed {
      logic                  hit;
      status_type            status;
      logic [USED_BITS-1:0]  own_used;
      logic [USED_BITS-1:0]  other_used;
   } rsp_word_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic scan_step;
      logic execute;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_needed;
      logic last_pair;
   } stat_type;

endpackage

`default_nettype wire

@@ src/bsot_ctrl.sv @@
// Controller state machine that sequences load, pair scan and completion.
`default_nettype none

module bsot_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  bsot_pkg::stat_type stat,
   output bsot_pkg::cmd_type  cmd,
   output logic              busy
);
   import bsot_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_DECODE = 5'b00010,
      ST_SCAN   = 5'b00100,
      ST_DRAIN  = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (stat.scan_needed) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.last_pair) begin
               state_in = ST_DRAIN;
            end
         end
         // The last pair read is compared in this cycle.
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.execute = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

@@ src/bsot_data.sv @@
// Datapath: box memories, set counts, pair scan counters and overlap compare.
`default_nettype none

module bsot_data #(
   parameter int MAX_BOXES  = 16,
   parameter int COORD_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bsot_pkg::cmd_type      cmd,
   output bsot_pkg::stat_type     stat,
   input  bsot_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   output bsot_pkg::rsp_word_type rsp_word
);
   import bsot_pkg::*;

   localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
   localparam int CW = $clog2(MAX_BOXES + 1);
   localparam int IW = (CW > INDEX_BITS) ? CW : INDEX_BITS;
   localparam int SW = COORD_BITS + 1;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] left;
      logic signed [COORD_BITS-1:0] top;
      logic signed [COORD_BITS-1:0] right;
      logic signed [COORD_BITS-1:0] bottom;
   } coord_box_type;

   // Takes the low COORD_BITS of a field, zero-filled above the field.
   function automatic logic signed [COORD_BITS-1:0] to_coord(
      input logic [FIELD_BITS-1:0] f
   );
      logic [COORD_LIMIT-1:0] wide;
      wide = COORD_LIMIT'(f);
      return $signed(wide[COORD_BITS-1:0]);
   endfunction

   req_word_type  req_ff;
   coord_box_type own_mem   [MAX_BOXES];
   coord_box_type other_mem [MAX_BOXES];
   coord_box_type own_rd_ff;
   coord_box_type other_rd_ff;
   logic          rd_valid_ff;
   logic          hit_ff;
   logic [AW-1:0] scan_i_ff;
   logic [AW-1:0] scan_j_ff;
   logic [CW-1:0] own_count_ff;
   logic [CW-1:0] other_count_ff;
   logic          rsp_valid_ff;
   rsp_word_type  rsp_ff;

   coord_box_type new_box;
   logic [CW-1:0] own_count_in;
   logic [CW-1:0] other_count_in;
   logic          own_we;
   logic          other_we;
   logic [AW-1:0] own_wr_addr;
   logic [AW-1:0] other_wr_addr;
   logic [IW-1:0] idx_ext;
   rsp_word_type  rsp_in;
   logic          own_last;
   logic          other_last;
   logic          overlap;

   logic signed [COORD_BITS-1:0] ox, oy, px, py;
   logic signed [SW-1:0] al, ar, at, ab, bl, br, bt, bb;

   // Execution of the latched word: writes, count updates and the result.
   always_comb begin
      new_box.left   = to_coord(req_ff.box_left);
      new_box.top    = to_coord(req_ff.box_top);
      new_box.right  = to_coord(req_ff.box_right);
      new_box.bottom = to_coord(req_ff.box_bottom);
      idx_ext        = IW'(req_ff.index);
      own_count_in   = own_count_ff;
      other_count_in = other_count_ff;
      own_we         = 1'b0;
      other_we       = 1'b0;
      own_wr_addr    = own_count_ff[AW-1:0];
      other_wr_addr  = other_count_ff[AW-1:0];
      rsp_in         = '0;
      rsp_in.status  = STAT_OK;
      case (req_ff.opcode)
         OP_APPEND_OWN: begin
            if (own_count_ff < CW'(MAX_BOXES)) begin
               own_we       = 1'b1;
               own_count_in = own_count_ff + CW'(1);
            end else begin
               rsp_in.status = STAT_FULL;
            end
         end
         OP_APPEND_OTHER: begin
            if (other_count_ff < CW'(MAX_BOXES)) begin
               other_we       = 1'b1;
               other_count_in = other_count_ff + CW'(1);
            end else begin
               rsp_in.status = STAT_FULL;
            end
         end
         OP_OVERWRITE_OWN: begin
            own_wr_addr = idx_ext[AW-1:0];
            if (idx_ext < IW'(own_count_ff) && idx_ext < IW'(MAX_BOXES)) begin
               own_we = 1'b1;
            end else begin
               rsp_in.status = STAT_RANGE;
            end
         end
         OP_OVERWRITE_OTHER: begin
            other_wr_addr = idx_ext[AW-1:0];
            if (idx_ext < IW'(other_count_ff) && idx_ext < IW'(MAX_BOXES)) begin
               other_we = 1'b1;
            end else begin
               rsp_in.status = STAT_RANGE;
            end
         end
         OP_CLEAR_OWN: begin
            own_count_in = '0;
         end
         OP_CLEAR_OTHER: begin
            other_count_in = '0;
         end
         OP_TEST: begin
            rsp_in.hit = hit_ff;
         end
         default: begin
         end
      endcase
      rsp_in.own_used   = USED_BITS'(own_count_in);
      rsp_in.other_used = USED_BITS'(other_count_in);
   end

   // Pair scan position: the other index runs fastest.
   assign own_last   = ((CW'(scan_i_ff) + CW'(1)) == own_count_ff);
   assign other_last = ((CW'(scan_j_ff) + CW'(1)) == other_count_ff);

   assign stat.last_pair   = own_last && other_last;
   assign stat.scan_needed = (req_ff.opcode == OP_TEST) &&
                             (own_count_ff != '0) && (other_count_ff != '0);

   // Overlap of the pair read in the previous cycle, both boxes shifted.
   assign ox = to_coord(req_ff.own_x);
   assign oy = to_coord(req_ff.own_y);
   assign px = to_coord(req_ff.other_x);
   assign py = to_coord(req_ff.other_y);

   assign al = SW'(own_rd_ff.left)     + SW'(ox);
   assign ar = SW'(own_rd_ff.right)    + SW'(ox);
   assign at = SW'(own_rd_ff.top)      + SW'(oy);
   assign ab = SW'(own_rd_ff.bottom)   + SW'(oy);
   assign bl = SW'(other_rd_ff.left)   + SW'(px);
   assign br = SW'(other_rd_ff.right)  + SW'(px);
   assign bt = SW'(other_rd_ff.top)    + SW'(py);
   assign bb = SW'(other_rd_ff.bottom) + SW'(py);

   assign overlap = (al < br) && (bl < ar) && (at < bb) && (bt < ab);

   always_ff @(posedge clock) begin
      if (cmd.execute && own_we) begin
         own_mem[own_wr_addr] <= new_box;
      end
      own_rd_ff <= own_mem[scan_i_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.execute && other_we) begin
         other_mem[other_wr_addr] <= new_box;
      end
      other_rd_ff <= other_mem[scan_j_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_word;
      end
      if (cmd.execute) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_count_ff   <= '0;
         other_count_ff <= '0;
         scan_i_ff      <= '0;
         scan_j_ff      <= '0;
         rd_valid_ff    <= 1'b0;
         hit_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rd_valid_ff  <= cmd.scan_step;
         rsp_valid_ff <= cmd.execute;
         if (cmd.execute) begin
            own_count_ff   <= own_count_in;
            other_count_ff <= other_count_in;
         end
         if (cmd.load) begin
            scan_i_ff <= '0;
            scan_j_ff <= '0;
            hit_ff    <= 1'b0;
         end else begin
            if (cmd.scan_step) begin
               if (other_last) begin
                  scan_j_ff <= '0;
                  scan_i_ff <= scan_i_ff + AW'(1);
               end else begin
                  scan_j_ff <= scan_j_ff + AW'(1);
               end
            end
            if (rd_valid_ff && overlap) begin
               hit_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

`default_nettype wire

@@ src/box_set_overlap_test.sv @@
// Top level of the box set overlap test block: controller, datapath and checks.
//
// The block keeps two sets of axis-aligned rectangles, own and other, each of
// up to MAX_BOXES entries. A word is taken at a rising edge where start is high
// and busy is low; it appends, overwrites, clears or tests. Every word gives
// exactly one result word, shown on rsp_word for a single cycle while
// rsp_valid is high. The receiver cannot stall the block, so it must capture
// the result in that cycle. Appends, overwrites, clears and the unused opcode
// pass through the decode and finish states before their result is shown. A
// test with both sets non-empty goes from decode to a scan that compares one
// pair of rectangles per cycle, reading one entry from each box memory
// through its single read port, then through drain and finish; a test with
// an empty set goes from decode straight to finish. Busy falls in the cycle
// in which the result is shown, so the next word may be offered alongside it.
// Box memory contents are not cleared at reset; only the set counts are, and
// no entry at or beyond a count is ever compared.
`default_nettype none

`include "assert_macros.svh"

module box_set_overlap_test #(
   parameter int MAX_BOXES  = 16,
   parameter int COORD_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  bsot_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   output bsot_pkg::rsp_word_type rsp_word
);
   import bsot_pkg::*;

   cmd_type  ctrl_cmd;
   stat_type ctrl_stat;

   // The controller sequences each word; all data storage lives in the datapath.
   bsot_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (ctrl_stat),
      .cmd   (ctrl_cmd),
      .busy  (busy)
   );

   bsot_data #(
      .MAX_BOXES  (MAX_BOXES),
      .COORD_BITS (COORD_BITS)
   ) u_data (
      .clock     (clock),
      .reset     (reset),
      .cmd       (ctrl_cmd),
      .stat      (ctrl_stat),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   // An accepted word always keeps the block busy in the following cycle.
   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   // Completion of a word always produces the result strobe next cycle.
   `ASSERT_NEXT(a_execute_strobe, clock, reset, ctrl_cmd.execute, rsp_valid)
   // No result may be shown while a pair scan is still running.
   `ASSERT_IMPLY(a_scan_quiet, clock, reset, ctrl_cmd.scan_step, !rsp_valid)
   // A dropped append or overwrite never reports a hit.
   `ASSERT_IMPLY(a_error_no_hit, clock, reset,
                 rsp_valid && (rsp_word.status != STAT_OK), !rsp_word.hit)

endmodule

`default_nettype wire

@@ tb/box_set_overlap_test_tb.sv @@
// Self-checking testbench for the box set overlap test block.
//
// The sender offers one word at a time on req_word and holds start high until
// the block takes the word at an edge where busy is low. At that edge the word
// is run through a local copy of the two rectangle sets and their counts. The
// result that copy gives is queued. A monitor takes each result word at the
// edge that ends its single valid cycle, and compares it field by field with
// the oldest queued result.
//
// The run opens with a short table of hand-picked words. Where a result can be
// read straight off the word (tests on an empty set, single appends and
// overwrites, dropped or not, clears, the unused opcode) the table carries
// that result. Every other row, and all of the random traffic that follows,
// is checked against the local copy. The random part is built from episodes.
// Most episodes are well-formed: optional clears, a run of appends to each
// set, a few overwrites, then one or more tests with fresh offsets. The rest
// are bursts of arbitrary words, the unused opcode among them. Set sizes
// stay small in most episodes so that tests stay short, but now and then a
// set is driven past full.
// The sender leaves gaps of random length before its words, mostly short and
// now and then long. Some episodes leave no gaps at all, so start stays high
// from word to word. A watchdog ends the run if nothing at all is taken for too
// long.
module box_set_overlap_test_tb;
   import bsot_pkg::*;

   localparam int SET_DEPTH = 16;
   localparam int WORD_TARGET = 1975;
   // A full test scans 256 pairs, and a long gap from the sender adds to the wait.
   localparam int IDLE_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 8;
   localparam logic [OPCODE_BITS-1:0] OP_UNUSED = 3'd7;

   typedef struct packed {
      logic signed [FIELD_BITS-1:0] left;
      logic signed [FIELD_BITS-1:0] top;
      logic signed [FIELD_BITS-1:0] right;
      logic signed [FIELD_BITS-1:0] bottom;
   } rect_type;

   typedef struct {
      req_word_type word;
      int reps;
      bit known;
      rsp_word_type result;
   } plan_row_type;

   logic clock;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_word_type req_word = '0;
   logic rsp_valid;
   rsp_word_type rsp_word;

   // The local copy of the block's state.
   rect_type own_rects [SET_DEPTH];
   rect_type other_rects [SET_DEPTH];
   int own_total = 0;
   int other_total = 0;

   rsp_word_type awaited_results [$];
   plan_row_type directed_plan [$];
   int words_sent = 0;
   int failures = 0;
   int idle_cycles = 0;
   bit no_gaps = 1'b0;

   box_set_overlap_test dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Strict overlap on both axes. The sums are formed in 32 bits, well clear
   // of any wrap for 16-bit coordinates and offsets.
   function automatic bit rects_overlap(input rect_type a, input int ax, input int ay,
                                        input rect_type b, input int bx, input int by);
      int al, ar, at, ab, bl, br, bt, bb;
      al = a.left + ax;
      ar = a.right + ax;
      at = a.top + ay;
      ab = a.bottom + ay;
      bl = b.left + bx;
      br = b.right + bx;
      bt = b.top + by;
      bb = b.bottom + by;
      return al < br && bl < ar && at < bb && bt < ab;
   endfunction

   // Applies one accepted word to the local sets and returns its result.
   function automatic rsp_word_type predict_result(input req_word_type w);
      rsp_word_type r;
      rect_type b;
      r = '0;
      r.status = STAT_OK;
      b = '{w.box_left, w.box_top, w.box_right, w.box_bottom};
      case (w.opcode)
         OP_APPEND_OWN: begin
            if (own_total < SET_DEPTH) begin
               own_rects[own_total] = b;
               own_total++;
            end else begin
               r.status = STAT_FULL;
            end
         end
         OP_APPEND_OTHER: begin
            if (other_total < SET_DEPTH) begin
               other_rects[other_total] = b;
               other_total++;
            end else begin
               r.status = STAT_FULL;
            end
         end
         OP_OVERWRITE_OWN: begin
            if (int'(w.index) < own_total) own_rects[w.index] = b;
            else r.status = STAT_RANGE;
         end
         OP_OVERWRITE_OTHER: begin
            if (int'(w.index) < other_total) other_rects[w.index] = b;
            else r.status = STAT_RANGE;
         end
         OP_CLEAR_OWN: own_total = 0;
         OP_CLEAR_OTHER: other_total = 0;
         OP_TEST: begin
            for (int i = 0; i < own_total; i++)
               for (int j = 0; j < other_total; j++)
                  if (rects_overlap(own_rects[i], w.own_x, w.own_y,
                                    other_rects[j], w.other_x, w.other_y))
                     r.hit = 1'b1;
         end
         default: ;
      endcase
      r.own_used = USED_BITS'(own_total);
      r.other_used = USED_BITS'(other_total);
      return r;
   endfunction

   function automatic req_word_type make_word(input logic [OPCODE_BITS-1:0] op, input int idx,
                                              input int l, input int t, input int r,
                                              input int b, input int ox, input int oy,
                                              input int px, input int py);
      req_word_type w;
      w.opcode = opcode_type'(op);
      w.index = INDEX_BITS'(idx);
      w.box_left = FIELD_BITS'(l);
      w.box_top = FIELD_BITS'(t);
      w.box_right = FIELD_BITS'(r);
      w.box_bottom = FIELD_BITS'(b);
      w.own_x = FIELD_BITS'(ox);
      w.own_y = FIELD_BITS'(oy);
      w.other_x = FIELD_BITS'(px);
      w.other_y = FIELD_BITS'(py);
      return w;
   endfunction

   function automatic rsp_word_type result_of(input logic hit, input status_type status,
                                              input int own_n, input int other_n);
      rsp_word_type r;
      r.hit = hit;
      r.status = status;
      r.own_used = USED_BITS'(own_n);
      r.other_used = USED_BITS'(other_n);
      return r;
   endfunction

   function automatic plan_row_type plan_row(input req_word_type w, input int reps,
                                             input bit known, input rsp_word_type r);
      plan_row_type p;
      p.word = w;
      p.reps = reps;
      p.known = known;
      p.result = r;
      return p;
   endfunction

   // Coordinates: often near the origin so that rectangles meet, with the
   // extremes and arbitrary bit patterns mixed in.
   function automatic int any_coord();
      case ($urandom_range(0, 7))
         0: return -32768;
         1: return 32767;
         2: return 0;
         3, 4: return int'($urandom_range(0, 65535)) - 32768;
         default: return int'($urandom_range(0, 400)) - 200;
      endcase
   endfunction

   function automatic int any_offset();
      if ($urandom_range(0, 3) == 0) return any_coord();
      return int'($urandom_range(0, 160)) - 80;
   endfunction

   function automatic req_word_type random_word(input logic [OPCODE_BITS-1:0] op);
      int l, t, r, b;
      if ($urandom_range(0, 3) == 0) begin
         l = any_coord();
         t = any_coord();
         r = any_coord();
         b = any_coord();
      end else begin
         // A small rectangle, now and then empty or inside out.
         l = int'($urandom_range(0, 400)) - 200;
         t = int'($urandom_range(0, 400)) - 200;
         r = l + int'($urandom_range(0, 120)) - 10;
         b = t + int'($urandom_range(0, 120)) - 10;
      end
      return make_word(op, $urandom_range(0, 15), l, t, r, b,
                       any_offset(), any_offset(), any_offset(), any_offset());
   endfunction

   function automatic int pick_gap();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return 0;
         6, 7, 8: return $urandom_range(1, 3);
         default: return $urandom_range(5, 40);
      endcase
   endfunction

   // Offers one word and waits for the block to take it. The result is
   // worked out at the edge of acceptance, so the sets stay in step with the
   // block. Rows of the table may supply a known result instead.
   task automatic send_word(input req_word_type w, input bit known, input rsp_word_type r);
      int gap;
      rsp_word_type predicted;
      gap = no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy);
      predicted = predict_result(w);
      awaited_results.push_back(known ? r : predicted);
      if (w.opcode != OP_UNUSED) words_sent++;
   endtask

   task automatic send_random(input logic [OPCODE_BITS-1:0] op);
      send_word(random_word(op), 1'b0, '0);
   endtask

   initial begin
      int n;
      // Row by row: empty sets first, then a single pair at the edges of the
      // coordinate range, rectangles that only touch, and finally both sets driven
      // to full with a scan that misses every pair and, after an overwrite, one that hits.
      directed_plan.push_back(plan_row(make_word(OP_TEST, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                                       1, 1'b1, result_of(1'b0, STAT_OK, 0, 0)));
      directed_plan.push_back(plan_row(make_word(OP_OVERWRITE_OWN, 0, 1, 2, 3, 4, 0, 0, 0, 0),
                                       1, 1'b1, result_of(1'b0, STAT_RANGE, 0, 0)));
      directed_plan.push_back(plan_row(make_word(OP_OVERWRITE_OTHER, 15, -1, -1, -1, -1,
                                                 -1, -1, -1, -1),
                                       1, 1'b1, result_of(1'b0, STAT_RANGE, 0, 0)));
      directed_plan.push_back(plan_row(make_word(OP_UNUSED, 15, -1, -1, -1, -1,
                                                 -1, -1, -1, -1),
                                       1, 1'b1, result_of(1'b0, STAT_OK, 0, 0)));
      directed_plan.push_back(plan_row(make_word(OP_CLEAR_OWN, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                                       1, 1'b1, result_of(1'b0, STAT_OK, 0, 0)));
      directed_plan.push_back(plan_row(make_word(OP_APPEND_OWN, 0, -32768, -32768, 32767,
                                                 32767, 0, 0, 0, 0),
                                       1, 1'b1, result_of(1'b0, STAT_OK, 1, 0)));
      directed_plan.push_back(plan_row(make_word(OP_TEST, 0, 0, 0, 0, 0, 32767, 32767,
                                                 32767, 32767),
                                       1, 1'b1, result_of(1'b0, STAT_OK, 1, 0)));
      directed_plan.push_back(plan_row(make_word(OP_APPEND_OTHER, 0, 0, 0, 1, 1, 0, 0, 0, 0),
                                       1, 1'b1, result_of(1'b0, STAT_OK, 1, 1)));
      directed_plan.push_back(plan_row(make_word(OP_TEST, 0, 0, 0, 0, 0, -32768, -32768,
                                                 32767, 32767),
                                       1, 1'b0, '0));
      directed_plan.push_back(plan_row(make_word(OP_TEST, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                                       1, 1'b0, '0));
      directed_plan.push_back(plan_row(make_word(OP_OVERWRITE_OWN, 0, 0, 0, 10, 10, 0, 0, 0, 0),
                                       1, 1'b1, result_of(1'b0, STAT_OK, 1, 1)));
      directed_plan.push_back(plan_row(make_word(OP_OVERWRITE_OTHER, 0, 10, 0, 20, 10,
                                                 0, 0, 0, 0),
                                       1, 1'b1, result_of(1'b0, STAT_OK, 1, 1)));
      // The right edge of own meets the left edge of other: no overlap.
      directed_plan.push_back(plan_row(make_word(OP_TEST, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                                       1, 1'b0, '0));
      directed_plan.push_back(plan_row(make_word(OP_TEST, 0, 0, 0, 0, 0, 0, 0, -1, 0),
                                       1, 1'b0, '0));
      directed_plan.push_back(plan_row(make_word(OP_OVERWRITE_OTHER, 1, 5, 5, 6, 6, 0, 0, 0, 0),
                                       1, 1'b1, result_of(1'b0, STAT_RANGE, 1, 1)));
      directed_plan.push_back(plan_row(make_word(OP_CLEAR_OTHER, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                                       1, 1'b1, result_of(1'b0, STAT_OK, 1, 0)));
      directed_plan.push_back(plan_row(make_word(OP_APPEND_OWN, 0, 32767, 32767, -32768,
                                                 -32768, 0, 0, 0, 0),
                                       15, 1'b0, '0));
      directed_plan.push_back(plan_row(make_word(OP_APPEND_OWN, 0, 7, 7, 8, 8, 0, 0, 0, 0),
                                       1, 1'b1, result_of(1'b0, STAT_FULL, 16, 0)));
      directed_plan.push_back(plan_row(make_word(OP_APPEND_OTHER, 0, -5, -5, 5, 5, 0, 0, 0, 0),
                                       16, 1'b0, '0));
      directed_plan.push_back(plan_row(make_word(OP_APPEND_OTHER, 0, 7, 7, 8, 8, 0, 0, 0, 0),
                                       1, 1'b1, result_of(1'b0, STAT_FULL, 16, 16)));
      directed_plan.push_back(plan_row(make_word(OP_TEST, 0, 0, 0, 0, 0, 32767, 0, 0, 0),
                                       1, 1'b0, '0));
      directed_plan.push_back(plan_row(make_word(OP_OVERWRITE_OWN, 15, -1, -1, 0, 0,
                                                 0, 0, 0, 0),
                                       1, 1'b1, result_of(1'b0, STAT_OK, 16, 16)));
      // The first and last own entries now meet the other set.
      directed_plan.push_back(plan_row(make_word(OP_TEST, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                                       1, 1'b0, '0));
      directed_plan.push_back(plan_row(make_word(OP_CLEAR_OWN, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                                       1, 1'b1, result_of(1'b0, STAT_OK, 0, 16)));
      directed_plan.push_back(plan_row(make_word(OP_CLEAR_OTHER, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                                       1, 1'b1, result_of(1'b0, STAT_OK, 0, 0)));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[k])
         repeat (directed_plan[k].reps)
            send_word(directed_plan[k].word, directed_plan[k].known, directed_plan[k].result);

      // Random episodes until enough words have gone in.
      while (words_sent < WORD_TARGET) begin
         no_gaps = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 9) < 7) begin
            if ($urandom_range(0, 2) != 0) send_random(OP_CLEAR_OWN);
            if ($urandom_range(0, 2) != 0) send_random(OP_CLEAR_OTHER);
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 18) : $urandom_range(0, 3);
            repeat (n) send_random(OP_APPEND_OWN);
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 18) : $urandom_range(0, 3);
            repeat (n) send_random(OP_APPEND_OTHER);
            repeat ($urandom_range(0, 2))
               send_random($urandom_range(0, 1) ? OP_OVERWRITE_OWN : OP_OVERWRITE_OTHER);
            repeat ($urandom_range(1, 4)) send_random(OP_TEST);
         end else begin
            repeat ($urandom_range(1, 6)) send_random(OPCODE_BITS'($urandom_range(0, 7)));
         end
      end
      start <= 1'b0;

      while (awaited_results.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   // Each result word lives for exactly one cycle and is taken at the edge
   // that ends it.
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid) begin
         if (awaited_results.size() == 0) begin
            $error("result word %h arrived with none outstanding", rsp_word);
            failures++;
         end else begin
            want = awaited_results.pop_front();
            if (rsp_word.hit !== want.hit) begin
               $error("hit: expected %0d, actual %0d", want.hit, rsp_word.hit);
               failures++;
            end
            if (rsp_word.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_word.status);
               failures++;
            end
            if (rsp_word.own_used !== want.own_used) begin
               $error("own_used: expected %0d, actual %0d", want.own_used, rsp_word.own_used);
               failures++;
            end
            if (rsp_word.other_used !== want.other_used) begin
               $error("other_used: expected %0d, actual %0d",
                      want.other_used, rsp_word.other_used);
               failures++;
            end
         end
      end
   end

   // Any edge that takes a word in either direction counts as progress.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

@@ filelist.f @@
+incdir+src
src/bsot_pkg.sv
src/bsot_ctrl.sv
src/bsot_data.sv
src/box_set_overlap_test.sv
tb/box_set_overlap_test_tb.sv
